// File: hdl/assert_macros.svh
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on aclk, off while reset is asserted.
`define LMED_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define LMED_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LMED_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lmed_pkg.sv
// Package: constants, codes and types of the list-mode event deframer.
`default_nettype none
package lmed_pkg;

    localparam int MODULES    = 8;
    localparam int MAX_HEADER = 16;
    localparam int MIN_HEADER = 4;

    localparam int MOD_W   = 3;
    localparam int WORD_W  = 32;
    localparam int LEN_W   = 14;
    localparam int HLEN_W  = 5;
    localparam int IDX_W   = 5;
    localparam int FACT_W  = 8;
    localparam int STAMP_W = 48;
    localparam int TS_W    = 56;
    localparam int CFG_IDX_W = 3;

    // header field positions in word 0
    localparam int HLEN_LSB = 12;
    localparam int ELEN_LSB = 17;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 5;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_HDR_LEN = 2'd1,
        ERR_SHORT   = 2'd2
    } err_t;

    typedef struct packed {
        logic [MOD_W-1:0]   module_id;
        logic [WORD_W-1:0]  word;
        logic [IDX_W-1:0]   index;
        logic               last;
        err_t               err;
        logic [STAMP_W-1:0] stamp;   // zero unless last
        logic [FACT_W-1:0]  factor;
    } item_t;

endpackage
`default_nettype wire

// File: hdl/list_mode_event_deframer.sv
// list_mode_event_deframer: top level, per-module list-mode header extraction.
// Accepted header words pass through the queue into the back part's output register (m_tvalid).
// Throughput: one word per cycle, any mix of modules, while the queue is not full;
//   the front part reads and updates the per-module state for each word.
// Reset: aresetn synchronous, active low; factors go to 1, all modules expect a header.
`default_nettype none
module list_mode_event_deframer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration: factor_0..factor_7 at index 0..7
    input  wire logic                           cfg_wr_en,
    input  wire logic [lmed_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lmed_pkg::FACT_W-1:0]    cfg_wdata,
    // input stream
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [lmed_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] data_word
    input  wire logic [lmed_pkg::S_TUSER_W-1:0] s_tuser,   // [2:0] module_req
    input  wire logic                           s_tlast,   // end_of_buffer
    // result stream
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] out_word, [36:32] word_index, [92:37] scaled_timestamp, [95:93] zero
    output      logic [lmed_pkg::M_TDATA_W-1:0] m_tdata,
    output      logic [lmed_pkg::M_TUSER_W-1:0] m_tuser,   // [2:0] out_module, [4:3] error
    output      logic                           m_tlast    // header_last
);
    import lmed_pkg::*;

    logic  accept;
    logic  push;
    item_t wr_item;
    logic  q_full;
    logic  q_pop;
    logic  q_not_empty;
    item_t rd_item;
    logic  eob_unused;

    // Parsing ignores buffer boundaries: per-module state carries events
    // across buffers, so tlast is only taken and dropped.
    assign eob_unused = s_tlast;

    // Ready only depends on queue room; the back part drains independently.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready && (eob_unused || !eob_unused);

    // Front: reads the word's module state, classifies header / header
    // body / trace / error, rewrites word 0 and gathers the timestamp.
    lmed_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .module_req (s_tuser[MOD_W-1:0]),
        .data_word  (s_tdata[WORD_W-1:0]),
        .push       (push),
        .item       (wr_item)
    );

    // Queue: absorbs output stalls so input keeps flowing.
    lmed_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_item   (wr_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_item   (rd_item)
    );

    // Back: scales the timestamp and holds the output transaction.
    lmed_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_item      (rd_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
`default_nettype wire

// File: hdl/lmed_front.sv
// Front: per-module header parsing, factor registers, queue entry build.
`default_nettype none
module lmed_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [lmed_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lmed_pkg::FACT_W-1:0]    cfg_wdata,
    input  wire logic                           accept,
    input  wire logic [lmed_pkg::MOD_W-1:0]     module_req,
    input  wire logic [lmed_pkg::WORD_W-1:0]    data_word,
    output      logic                           push,
    output      lmed_pkg::item_t                item
);
    import lmed_pkg::*;

    logic [FACT_W-1:0]  factor_reg     [MODULES];
    logic [LEN_W-1:0]   words_left_reg [MODULES];
    logic [LEN_W-1:0]   position_reg   [MODULES];
    logic [HLEN_W-1:0]  hdr_words_reg  [MODULES];
    logic [WORD_W-1:0]  stamp_low_reg  [MODULES];
    logic [15:0]        stamp_high_reg [MODULES];

    logic               in_range;
    logic               is_header;
    logic [HLEN_W-1:0]  hlen;
    logic [LEN_W-1:0]   elen;
    logic [LEN_W-1:0]   pos;
    logic               in_hdr;
    logic               last;
    logic               upd;
    err_t               err;

    assign in_range  = {1'b0, module_req} < (MOD_W+1)'(MODULES);
    assign hlen      = data_word[HLEN_LSB +: HLEN_W];
    assign elen      = data_word[ELEN_LSB +: LEN_W];
    assign is_header = (words_left_reg[module_req] == '0);
    assign pos       = position_reg[module_req];
    assign in_hdr    = pos < LEN_W'(hdr_words_reg[module_req]);
    assign last      = ((LEN_W+1)'(pos) + (LEN_W+1)'(1))
                       == (LEN_W+1)'(hdr_words_reg[module_req]);
    assign upd       = accept && in_range;

    always_comb begin
        if (hlen < HLEN_W'(MIN_HEADER) || hlen > HLEN_W'(MAX_HEADER)) begin
            err = ERR_HDR_LEN;
        end else if (elen < LEN_W'(hlen)) begin
            err = ERR_SHORT;
        end else begin
            err = ERR_NONE;
        end
    end

    always_comb begin
        item.module_id = module_req;
        item.factor    = factor_reg[module_req];
        item.stamp     = '0;
        item.err       = ERR_NONE;
        item.last      = 1'b0;
        item.index     = '0;
        item.word      = data_word;
        if (is_header) begin
            item.err = err;
            if (err == ERR_NONE) begin
                // event length field replaced by the header length
                item.word = {data_word[WORD_W-1], (LEN_W-HLEN_W)'(0), hlen,
                             data_word[ELEN_LSB-1:0]};
            end
        end else begin
            item.index = pos[IDX_W-1:0];
            item.last  = last;
            if (last) begin
                item.stamp = {stamp_high_reg[module_req], stamp_low_reg[module_req]};
            end
        end
        push = upd && (is_header || in_hdr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MODULES; i++) begin
                factor_reg[i]     <= FACT_W'(1);
                words_left_reg[i] <= '0;
                position_reg[i]   <= '0;
                hdr_words_reg[i]  <= '0;
            end
        end else begin
            if (cfg_wr_en && ({1'b0, cfg_index} < (CFG_IDX_W+1)'(MODULES))) begin
                factor_reg[cfg_index] <= cfg_wdata;
            end
            if (upd) begin
                if (is_header) begin
                    if (err == ERR_NONE) begin
                        words_left_reg[module_req] <= elen - LEN_W'(1);
                        position_reg[module_req]   <= LEN_W'(1);
                        hdr_words_reg[module_req]  <= hlen;
                    end
                end else begin
                    words_left_reg[module_req] <= words_left_reg[module_req] - LEN_W'(1);
                    position_reg[module_req]   <= pos + LEN_W'(1);
                end
            end
        end
    end

    // timestamp capture, header body words 1 and 2 only
    always_ff @(posedge aclk) begin
        if (upd && !is_header && in_hdr) begin
            if (pos == LEN_W'(1)) begin
                stamp_low_reg[module_req] <= data_word;
            end
            if (pos == LEN_W'(2)) begin
                stamp_high_reg[module_req] <= data_word[15:0];
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/lmed_queue.sv
// Queue: short FIFO of parsed items between front and back.
`default_nettype none
`include "assert_macros.svh"
module lmed_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire lmed_pkg::item_t wr_item,
    output      logic            full,
    input  wire logic            pop,
    output      logic            not_empty,
    output      lmed_pkg::item_t rd_item
);
    import lmed_pkg::*;

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `LMED_ASSERT_IMP(a_no_push_full, full, !push, "push into full queue")
    `LMED_ASSERT_IMP(a_no_pop_empty, !not_empty, !pop, "pop from empty queue")

endmodule
`default_nettype wire

// File: hdl/lmed_back.sv
// Back: timestamp scaling and output register of the result stream.
`default_nettype none
`include "assert_macros.svh"
module lmed_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_not_empty,
    input  wire lmed_pkg::item_t                q_item,
    output      logic                           q_pop,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [lmed_pkg::M_TDATA_W-1:0] m_tdata,
    output      logic [lmed_pkg::M_TUSER_W-1:0] m_tuser,
    output      logic                           m_tlast
);
    import lmed_pkg::*;

    logic              valid_reg;
    logic [MOD_W-1:0]  module_reg;
    logic [WORD_W-1:0] word_reg;
    logic [IDX_W-1:0]  index_reg;
    logic              last_reg;
    logic [TS_W-1:0]   ts_reg;
    err_t              err_reg;
    logic [TS_W-1:0]   product;

    // 48x8; stamp is zero on non-last items so the product is too
    assign product = TS_W'(q_item.stamp) * TS_W'(q_item.factor);
    assign q_pop   = q_not_empty && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            module_reg <= q_item.module_id;
            word_reg   <= q_item.word;
            index_reg  <= q_item.index;
            last_reg   <= q_item.last;
            ts_reg     <= product;
            err_reg    <= q_item.err;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = {err_reg, module_reg};
    assign m_tdata  = {(M_TDATA_W-WORD_W-IDX_W-TS_W)'(0), ts_reg, index_reg, word_reg};

    `LMED_ASSERT_IMP(a_err_not_last, m_tvalid && (err_reg != ERR_NONE), !m_tlast,
        "error result flagged as header end")
    `LMED_ASSERT_IMP(a_ts_only_last, m_tvalid && !m_tlast, ts_reg == '0,
        "timestamp on a non-final header word")
    `LMED_ASSERT_NXT(a_pop_loads, q_pop, m_tvalid, "popped item not presented")

endmodule
`default_nettype wire
